FILE: rtl/rpn_pkg.sv
// Types, constants and microcode ROM for the four-level RPN stack ALU.
`timescale 1ns / 1ps

package rpn_pkg;

	localparam int DW       = 32;                    // data width, signed fixed point
	localparam int FRAC     = 16;                    // fraction bits
	localparam int WIDE_W   = 2 * DW;                // full product width
	localparam int QW       = DW + FRAC;             // dividend and quotient width
	localparam int CNT_W    = $clog2(QW);
	localparam int CMD_W    = 3;
	localparam int ST_W     = 2;
	localparam int IN_W     = ((DW + 7) / 8) * 8;
	localparam int OUT_W    = ((4 * DW + ST_W + 7) / 8) * 8;
	localparam int UPC_W    = 4;

	typedef logic [DW-1:0]    word_t;
	typedef logic [WIDE_W-1:0] wide_t;
	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [ST_W-1:0]  status_t;
	typedef logic [UPC_W-1:0] upc_t;

	// Command codes
	localparam cmd_t CMD_PUSH = 3'd0;
	localparam cmd_t CMD_ADD  = 3'd1;
	localparam cmd_t CMD_SUB  = 3'd2;
	localparam cmd_t CMD_MUL  = 3'd3;
	localparam cmd_t CMD_DIV  = 3'd4;

	// Status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_DIV0  = 2'd1;
	localparam status_t ST_BADOP = 2'd2;
	localparam status_t ST_SAT   = 2'd3;

	localparam word_t W_SIGN = {1'b1, {(DW-1){1'b0}}};
	localparam word_t W_MAXP = {1'b0, {(DW-1){1'b1}}};

	// Datapath action of one microstep
	typedef enum logic [3:0] {
		UOP_LATCH,
		UOP_PUSH,
		UOP_POP2,
		UOP_ADD,
		UOP_SUB,
		UOP_MULP,
		UOP_MULW,
		UOP_DIVINIT,
		UOP_DIVSTEP,
		UOP_DIVW,
		UOP_BAD,
		UOP_EMIT
	} uop_t;

	// Sequencing of one microstep
	typedef enum logic [2:0] {
		COND_NEXT,      // advance
		COND_GOTO,      // jump to target
		COND_START,     // hold until a transaction is taken, then branch on push
		COND_OPER,      // branch on the operator
		COND_DIV0,      // jump to target on a zero divisor, else advance
		COND_LOOP,      // hold until the last divide step, then advance
		COND_OUT        // hold until the output register is free, then jump
	} cond_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		upc_t  target;
	} ctrl_t;

	// Microprogram addresses
	localparam upc_t A_WAIT    = 4'd0;
	localparam upc_t A_PUSH    = 4'd1;
	localparam upc_t A_POP     = 4'd2;
	localparam upc_t A_ADD     = 4'd3;
	localparam upc_t A_SUB     = 4'd4;
	localparam upc_t A_MUL     = 4'd5;
	localparam upc_t A_MULW    = 4'd6;
	localparam upc_t A_DIV     = 4'd7;
	localparam upc_t A_DIVSTEP = 4'd8;
	localparam upc_t A_DIVW    = 4'd9;
	localparam upc_t A_BAD     = 4'd10;
	localparam upc_t A_EMIT    = 4'd11;

	function automatic ctrl_t ucode_rom(input upc_t addr);
		ctrl_t cw;
		case (addr)
			A_WAIT:    cw = '{UOP_LATCH,   COND_START, A_WAIT};
			A_PUSH:    cw = '{UOP_PUSH,    COND_GOTO,  A_EMIT};
			A_POP:     cw = '{UOP_POP2,    COND_OPER,  A_WAIT};
			A_ADD:     cw = '{UOP_ADD,     COND_GOTO,  A_EMIT};
			A_SUB:     cw = '{UOP_SUB,     COND_GOTO,  A_EMIT};
			A_MUL:     cw = '{UOP_MULP,    COND_NEXT,  A_WAIT};
			A_MULW:    cw = '{UOP_MULW,    COND_GOTO,  A_EMIT};
			A_DIV:     cw = '{UOP_DIVINIT, COND_DIV0,  A_EMIT};
			A_DIVSTEP: cw = '{UOP_DIVSTEP, COND_LOOP,  A_WAIT};
			A_DIVW:    cw = '{UOP_DIVW,    COND_GOTO,  A_EMIT};
			A_BAD:     cw = '{UOP_BAD,     COND_GOTO,  A_EMIT};
			A_EMIT:    cw = '{UOP_EMIT,    COND_OUT,   A_WAIT};
			default:   cw = '{UOP_LATCH,   COND_GOTO,  A_WAIT};
		endcase
		return cw;
	endfunction

	// Entry point of each operator after both operands are popped
	function automatic upc_t oper_addr(input cmd_t cmd);
		upc_t a;
		case (cmd)
			CMD_ADD: a = A_ADD;
			CMD_SUB: a = A_SUB;
			CMD_MUL: a = A_MUL;
			CMD_DIV: a = A_DIV;
			default: a = A_BAD;
		endcase
		return a;
	endfunction

	function automatic word_t magnitude(input word_t v);
		return v[DW-1] ? (~v + word_t'(1)) : v;
	endfunction

	typedef struct packed {
		logic  sat;
		word_t val;
	} satres_t;

	// Apply a sign to an unsigned magnitude, clamping to the signed range
	function automatic satres_t sign_sat(input logic neg, input wide_t q);
		wide_t   lim;
		word_t   m;
		satres_t r;
		lim   = neg ? WIDE_W'(W_SIGN) : WIDE_W'(W_MAXP);
		r.sat = (q > lim);
		m     = r.sat ? lim[DW-1:0] : q[DW-1:0];
		r.val = neg ? (~m + word_t'(1)) : m;
		return r;
	endfunction

endpackage

FILE: rtl/rpn_four_level_stack_alu_core.sv
// Four-level RPN stack (X, Y, Z, T) with a microcoded saturating fixed-point ALU.
`timescale 1ns / 1ps

// Usage:
//   Input channel s_*: one transaction is one command. s_tuser carries the
//   command (push, add, subtract, multiply, divide; other codes are unknown
//   operators), s_tdata the signed Q16.16 value that a push loads into X.
//   Output channel m_*: one transaction per command, holding X, Y, Z, T after
//   the command and a status (ok, divide by zero, unknown operator, saturated).
//   A microprogram in a small ROM runs each command, one microstep per cycle
//   except where a step holds. A push loads X, then emits; add, subtract and
//   unknown operators pop both operands, then compute or flag and emit; multiply
//   forms the product, then writes it back; divide goes to emit on a zero
//   divisor, else runs 48 radix-2 steps of the iterative divider and writes back.
//   A new command is taken in the cycle after the result is loaded.
//   The output register holds a result while m_tready is low; the sequencer
//   may take and compute the next command meanwhile and waits in its last
//   step until the register is free.
//   Reset clears the stack to zero, empties the output register and returns
//   the sequencer to its wait step.
module rpn_four_level_stack_alu_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [rpn_pkg::IN_W-1:0]   s_tdata,   // value[31:0]
	input  logic [rpn_pkg::CMD_W-1:0]  s_tuser,   // cmd[2:0]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [rpn_pkg::OUT_W-1:0]  m_tdata    // x_value, y_value, z_value, t_value, status
);
	import rpn_pkg::*;

	// Sequencer
	upc_t    upc_q;
	upc_t    upc_next;
	ctrl_t   cw;

	// Stack
	word_t   x_q, y_q, z_q, t_q;

	// Datapath registers
	cmd_t    cmd_q;
	word_t   val_q;
	status_t status_q;
	word_t   a_q, b_q, ma_q, mb_q;
	logic    neg_q;
	wide_t   prod_q;
	word_t   rem_q;
	logic [QW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;

	// Output register
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic    s_accept, out_free, cnt_last, div_zero;
	word_t   sum, diff, add_res, sub_res;
	logic    add_ovf, sub_ovf;
	satres_t mul_sat, div_sat;
	logic [DW:0]   rem_sh;
	logic          rem_ge;
	word_t         rem_next;

	assign cw       = ucode_rom(upc_q);
	assign s_tready = (cw.cond == COND_START);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign cnt_last = (cnt_q == CNT_W'(QW - 1));
	assign div_zero = (mb_q == '0);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Add and subtract with saturation
	assign sum     = a_q + b_q;
	assign diff    = a_q - b_q;
	assign add_ovf = (a_q[DW-1] == b_q[DW-1]) && (sum[DW-1] != a_q[DW-1]);
	assign sub_ovf = (a_q[DW-1] != b_q[DW-1]) && (diff[DW-1] != a_q[DW-1]);
	assign add_res = add_ovf ? (a_q[DW-1] ? W_SIGN : W_MAXP) : sum;
	assign sub_res = sub_ovf ? (a_q[DW-1] ? W_SIGN : W_MAXP) : diff;

	assign mul_sat = sign_sat(neg_q, prod_q >> FRAC);
	assign div_sat = sign_sat(neg_q, WIDE_W'(quo_q));

	// One restoring divide step: bring in the next dividend bit
	assign rem_sh   = {rem_q, quo_q[QW-1]};
	assign rem_ge   = (rem_sh >= {1'b0, mb_q});
	assign rem_next = rem_ge ? DW'(rem_sh - {1'b0, mb_q}) : rem_sh[DW-1:0];

	always_comb begin
		upc_next = upc_q;
		case (cw.cond)
			COND_NEXT:  upc_next = upc_q + upc_t'(1);
			COND_GOTO:  upc_next = cw.target;
			COND_START: begin
				if (s_accept) begin
					upc_next = (s_tuser == CMD_PUSH) ? A_PUSH : A_POP;
				end
			end
			COND_OPER:  upc_next = oper_addr(cmd_q);
			COND_DIV0:  upc_next = div_zero ? cw.target : upc_q + upc_t'(1);
			COND_LOOP:  upc_next = cnt_last ? upc_q + upc_t'(1) : upc_q;
			COND_OUT:   upc_next = out_free ? cw.target : upc_q;
			default:    upc_next = A_WAIT;
		endcase
	end

	// Control state and stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q      <= A_WAIT;
			m_tvalid_q <= 1'b0;
			x_q        <= '0;
			y_q        <= '0;
			z_q        <= '0;
			t_q        <= '0;
		end else begin
			upc_q <= upc_next;
			if (cw.uop == UOP_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (cw.uop)
				UOP_PUSH: begin
					t_q <= z_q; z_q <= y_q; y_q <= x_q; x_q <= val_q;
				end
				UOP_POP2: begin
					x_q <= z_q; y_q <= t_q; z_q <= t_q;
				end
				UOP_ADD: begin
					t_q <= z_q; z_q <= y_q; y_q <= x_q; x_q <= add_res;
				end
				UOP_SUB: begin
					t_q <= z_q; z_q <= y_q; y_q <= x_q; x_q <= sub_res;
				end
				UOP_MULW: begin
					t_q <= z_q; z_q <= y_q; y_q <= x_q; x_q <= mul_sat.val;
				end
				UOP_DIVW: begin
					t_q <= z_q; z_q <= y_q; y_q <= x_q; x_q <= div_sat.val;
				end
				default: ;
			endcase
		end
	end

	// Operands, arithmetic units and output payload
	always_ff @(posedge clk) begin
		case (cw.uop)
			UOP_LATCH: begin
				if (s_accept) begin
					cmd_q    <= s_tuser;
					val_q    <= s_tdata[DW-1:0];
					status_q <= ST_OK;
				end
			end
			UOP_POP2: begin
				b_q   <= x_q;
				a_q   <= y_q;
				mb_q  <= magnitude(x_q);
				ma_q  <= magnitude(y_q);
				neg_q <= x_q[DW-1] ^ y_q[DW-1];
			end
			UOP_ADD: begin
				if (add_ovf) status_q <= ST_SAT;
			end
			UOP_SUB: begin
				if (sub_ovf) status_q <= ST_SAT;
			end
			UOP_MULP: prod_q <= ma_q * mb_q;
			UOP_MULW: begin
				if (mul_sat.sat) status_q <= ST_SAT;
			end
			UOP_DIVINIT: begin
				if (div_zero) status_q <= ST_DIV0;
				rem_q <= '0;
				quo_q <= QW'(ma_q) << FRAC;
				cnt_q <= '0;
			end
			UOP_DIVSTEP: begin
				rem_q <= rem_next;
				quo_q <= {quo_q[QW-2:0], rem_ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			UOP_DIVW: begin
				if (div_sat.sat) status_q <= ST_SAT;
			end
			UOP_BAD: status_q <= ST_BADOP;
			UOP_EMIT: begin
				if (out_free) begin
					m_tdata_q <= OUT_W'({status_q, t_q, z_q, y_q, x_q});
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_one_per_wait: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_tready)
		else $error("second command taken while one is in progress");

	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= A_EMIT)
		else $error("microprogram counter outside the program");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == A_DIVSTEP) |-> !div_zero)
		else $error("divide loop running with a zero divisor");
`endif

endmodule
